@@ rtl/qdac_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qdac_pkg
// Shared types and constants for the four-channel DAC delta update block.
// ----------------------------------------------------------------------------
package qdac_pkg;

  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int VAL_W      = 16;
  localparam int CODE_W     = 16;
  localparam int FRAME_W    = 19;
  localparam int CH_SHIFT   = 17;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  // result kinds
  localparam logic KIND_STORE  = 1'b0;
  localparam logic KIND_STROBE = 1'b1;

  // one classified item: which channels changed and their new codes
  typedef struct packed {
    logic [NUM_CH-1:0]             mask;
    logic [NUM_CH-1:0][CODE_W-1:0] code;
  } qdac_entry_t;

endpackage : qdac_pkg
`default_nettype wire

@@ rtl/qdac_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qdac_front
// Input pipeline: captures items, maps values to codes, compares against the
// stored codes and pushes a change mask with the codes into the queue.
// ----------------------------------------------------------------------------
module qdac_front
  import qdac_pkg::*;
#(
  parameter int DAC_MAX_CODE = 65535
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  enable,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [NUM_CH-1:0][VAL_W-1:0] in_val,
  output logic                       push_valid,
  output qdac_entry_t                push_data,
  input  wire logic                  q_full
);

  localparam logic [CODE_W-1:0] MAXC = CODE_W'(DAC_MAX_CODE);

  logic                           s1_valid_r, s1_valid_nxt;
  logic [NUM_CH-1:0][VAL_W-1:0]   s1_val_r;
  logic                           s2_valid_r, s2_valid_nxt;
  logic [NUM_CH-1:0][CODE_W-1:0]  s2_code_r, s2_code_nxt;
  logic [NUM_CH-1:0][CODE_W-1:0]  last_code_r, last_code_nxt;
  logic [NUM_CH-1:0]              code_valid_r, code_valid_nxt;

  logic              s2_free, s1_free, s2_adv, s1_adv, accept;
  logic [NUM_CH-1:0] mask;

  assign s2_adv   = s2_valid_r && !q_full;
  assign s2_free  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && !in_stall;

  // code = ((32768 - x) * MAX + 32768) >> 16, one multiplier per lane
  always_comb begin
    logic [VAL_W+1:0]   span_w;
    logic [VAL_W:0]     span;
    logic [2*VAL_W:0]   sum;
    logic [VAL_W:0]     q;
    for (int i = 0; i < NUM_CH; i++) begin
      span_w = 18'd32768 - {{2{s1_val_r[i][VAL_W-1]}}, s1_val_r[i]};
      span   = span_w[VAL_W:0];
      sum    = 33'(span) * 33'(MAXC) + 33'd32768;
      q      = sum[2*VAL_W:VAL_W];
      if (q > 17'(MAXC)) begin
        s2_code_nxt[i] = MAXC;
      end else begin
        s2_code_nxt[i] = q[CODE_W-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      mask[i] = !code_valid_r[i] || (last_code_r[i] != s2_code_r[i]);
    end
  end

  assign push_valid     = s2_valid_r && (mask != '0);
  assign push_data.mask = mask;
  assign push_data.code = s2_code_r;

  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    s2_valid_nxt   = s2_valid_r;
    last_code_nxt  = last_code_r;
    code_valid_nxt = code_valid_r;
    if (s2_adv) begin
      s2_valid_nxt   = 1'b0;
      code_valid_nxt = '1;
      last_code_nxt  = s2_code_r;
    end
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      s2_valid_nxt = 1'b1;
    end
    // items taken while disabled are dropped here
    if (accept) begin
      s1_valid_nxt = enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      code_valid_r <= '0;
      last_code_r  <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      code_valid_r <= code_valid_nxt;
      last_code_r  <= last_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_val_r <= in_val;
    end
    if (s1_adv) begin
      s2_code_r <= s2_code_nxt;
    end
  end

endmodule : qdac_front
`default_nettype wire

@@ rtl/qdac_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qdac_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module qdac_fifo
  import qdac_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire qdac_entry_t  push_data,
  output logic              full,
  output logic              not_empty,
  input  wire logic         pop,
  output qdac_entry_t       pop_data
);

  qdac_entry_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : qdac_fifo
`default_nettype wire

@@ rtl/qdac_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qdac_back
// Output sequencer: walks the change mask of one queued item, sends a store
// frame per changed channel and closes with the load strobe.
// ----------------------------------------------------------------------------
module qdac_back
  import qdac_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire qdac_entry_t         q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_kind,
  output logic [FRAME_W-1:0]       out_frame_word,
  output logic                     out_last_of_run
);

  logic                          cur_valid_r, cur_valid_nxt;
  logic [NUM_CH-1:0]             mask_r, mask_nxt;
  logic [NUM_CH-1:0][CODE_W-1:0] code_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          kind_r, kind_nxt;
  logic [FRAME_W-1:0]            frame_r, frame_nxt;
  logic                          last_r, last_nxt;
  logic                          out_free;
  logic [CH_W-1:0]               ch;

  assign out_free = !out_valid_r || !out_stall;

  // lowest changed channel goes first
  always_comb begin
    ch = '0;
    priority if (mask_r[0]) ch = CH_W'(0);
    else if (mask_r[1])     ch = CH_W'(1);
    else if (mask_r[2])     ch = CH_W'(2);
    else                    ch = CH_W'(3);
  end

  assign q_pop = q_not_empty && (!cur_valid_r || (out_free && mask_r == '0));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    frame_nxt     = frame_r;
    last_nxt      = last_r;
    if (cur_valid_r && out_free) begin
      out_valid_nxt = 1'b1;
      if (mask_r != '0) begin
        kind_nxt     = KIND_STORE;
        frame_nxt    = {ch, 1'b0, code_r[ch]};
        last_nxt     = 1'b0;
        mask_nxt[ch] = 1'b0;
      end else begin
        kind_nxt      = KIND_STROBE;
        frame_nxt     = '0;
        last_nxt      = 1'b1;
        cur_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      mask_nxt      = q_data.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    frame_r <= frame_nxt;
    last_r  <= last_nxt;
    if (q_pop) begin
      code_r <= q_data.code;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_frame_word  = frame_r;
  assign out_last_of_run = last_r;

endmodule : qdac_back
`default_nettype wire

@@ rtl/quad_dac_delta_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quad_dac_delta_update
// Four-channel DAC update with change detection: emits a store frame per
// changed channel code, followed by a load strobe.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall) carries four signed Q1.15 values.
//    An item is taken when in_valid is high and in_stall low.
//  - Result channel (out_valid / out_stall) carries one store frame per
//    changed channel in channel order, then a load strobe with
//    out_last_of_run set. An item with no change gives no result.
//  - cfg_wr_en / cfg_wr_data write the enable bit; while it is clear, items
//    are taken and dropped. Write it only while the block is idle.
//  - A taken item passes the input register, the code register, the queue,
//    the sequencer and its result register. The sequencer sends one result
//    a cycle while out_stall is low; N changed channels give N+1 results.
//  - Input takes an item every cycle while the 4-entry queue between the
//    code pipeline and sequencer has room; a full queue stalls the pipeline.
//  - When out_stall is high the result register holds and the sequencer
//    waits; the queue and pipeline fill and then stall the input.
//  - Reset clears the enable bit, the queue and all stored codes' valid
//    flags, so the first item after enabling writes every channel.
// ----------------------------------------------------------------------------
module quad_dac_delta_update
  import qdac_pkg::*;
#(
  parameter int DAC_MAX_CODE = 65535
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VAL_W-1:0]   in_chan_a,
  input  wire logic [VAL_W-1:0]   in_chan_b,
  input  wire logic [VAL_W-1:0]   in_chan_c,
  input  wire logic [VAL_W-1:0]   in_chan_d,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_kind,
  output logic [FRAME_W-1:0]      out_frame_word,
  output logic                    out_last_of_run
);

  logic                          enable_r;
  logic [NUM_CH-1:0][VAL_W-1:0]  in_val;
  logic                          push_valid, q_full, q_not_empty, q_pop;
  qdac_entry_t                   push_data, pop_data;

  assign in_val[0] = in_chan_a;
  assign in_val[1] = in_chan_b;
  assign in_val[2] = in_chan_c;
  assign in_val[3] = in_chan_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  qdac_front #(
    .DAC_MAX_CODE (DAC_MAX_CODE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (enable_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_val     (in_val),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  qdac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_data  (pop_data)
  );

  qdac_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_frame_word  (out_frame_word),
    .out_last_of_run (out_last_of_run)
  );

endmodule : quad_dac_delta_update
`default_nettype wire
